// ===== rtl/pcrp_pkg.sv =====
// shared types and constants for the picture-unit cpu register port
// no dependencies
`default_nettype none

package pcrp_pkg;

    localparam int OBJECT_TABLE_DEPTH_DEF = 256;
    localparam int VIDEO_ADDR_BITS_DEF    = 14;

    localparam int ADDR_W       = 15;
    localparam int PALETTE_BASE = 'h3F00;
    localparam int ROW_STEP     = 32;

    typedef enum logic [1:0] {
        CMD_READ        = 2'd0,
        CMD_WRITE       = 2'd1,
        CMD_LOAD_STATUS = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } t_reg_index;

    // beat held while the memories answer
    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       sel_oam;
        logic       sel_vid;
        logic       palette;
    } t_s1;

endpackage

`default_nettype wire

// ===== rtl/pcrp_spram.sv =====
// single-port synchronous ram, registered read data
// no dependencies
`default_nettype none

module pcrp_spram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppu_cpu_register_port.sv =====
// Accepts one access beat per clock while the output side is not stalled and
// returns one result beat for each through the stage-1 and output registers.
// Control, mask, status, scroll and address registers live in flops and
// update when the beat is accepted; the object table and video memory are
// single-port rams read at acceptance, whose registered read data is taken
// while the beat sits in stage 1. Ram contents are undefined until written.
// top level, uses pcrp_pkg and pcrp_spram
`default_nettype none

module ppu_cpu_register_port
    import pcrp_pkg::*;
#(
    parameter int OBJECT_TABLE_DEPTH = OBJECT_TABLE_DEPTH_DEF,
    parameter int VIDEO_ADDR_BITS    = VIDEO_ADDR_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [2:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic [2:0] i_status_flags,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [7:0] o_read_data,
    output logic            o_access_error
);

    localparam int OAM_AW = $clog2(OBJECT_TABLE_DEPTH);

    logic [7:0]        r_ctrl, n_ctrl;
    logic [7:0]        r_mask, n_mask;
    logic [7:0]        r_status, n_status;
    logic [7:0]        r_obj_addr, n_obj_addr;
    logic [ADDR_W-1:0] r_t, n_t;
    logic [ADDR_W-1:0] r_v, n_v;
    logic [2:0]        r_fine_x, n_fine_x;
    logic              r_toggle, n_toggle;
    logic [7:0]        r_read_buf;

    logic              r_s1_valid;
    t_s1               r_s1, n_s1;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_err;

    logic              s1_adv;
    logic              accept;
    logic              oam_en, oam_we, vid_en, vid_we;
    logic [7:0]        oam_q, vid_q;
    logic [7:0]        s1_data;
    logic [ADDR_W-1:0] step;
    t_command          cmd;
    t_reg_index        reg_idx;

    assign cmd     = t_command'(i_command);
    assign reg_idx = t_reg_index'(i_reg_index);

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    assign step = r_ctrl[2] ? ADDR_W'(ROW_STEP) : ADDR_W'(1);

    always_comb begin
        n_ctrl     = r_ctrl;
        n_mask     = r_mask;
        n_status   = r_status;
        n_obj_addr = r_obj_addr;
        n_t        = r_t;
        n_v        = r_v;
        n_fine_x   = r_fine_x;
        n_toggle   = r_toggle;
        n_s1       = '0;
        oam_en     = 1'b0;
        oam_we     = 1'b0;
        vid_en     = 1'b0;
        vid_we     = 1'b0;
        unique case (cmd)
            CMD_READ: begin
                unique case (reg_idx)
                    REG_CTRL, REG_MASK, REG_OAM_ADDR: begin
                        n_s1.err = 1'b1;
                    end
                    REG_STATUS: begin
                        n_s1.data   = r_status;
                        n_status[7] = 1'b0;
                        n_toggle    = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        n_s1.sel_oam = 1'b1;
                        oam_en       = 1'b1;
                    end
                    REG_DATA: begin
                        n_s1.sel_vid = 1'b1;
                        n_s1.palette = r_v[VIDEO_ADDR_BITS-1:0]
                                       >= VIDEO_ADDR_BITS'(PALETTE_BASE);
                        vid_en       = 1'b1;
                        n_v          = r_v + step;
                    end
                    REG_SCROLL, REG_ADDR: begin
                    end
                endcase
            end
            CMD_WRITE: begin
                unique case (reg_idx)
                    REG_CTRL: begin
                        n_ctrl       = i_write_data;
                        n_t[11:10]   = i_write_data[1:0];
                    end
                    REG_MASK: begin
                        n_mask = i_write_data;
                    end
                    REG_STATUS: begin
                        n_s1.err = 1'b1;
                    end
                    REG_OAM_ADDR: begin
                        n_obj_addr = i_write_data;
                    end
                    REG_OAM_DATA: begin
                        oam_en     = 1'b1;
                        oam_we     = 1'b1;
                        n_obj_addr = r_obj_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x = i_write_data[2:0];
                            n_t[4:0] = i_write_data[7:3];
                            n_toggle = 1'b1;
                        end else begin
                            n_t[14:12] = i_write_data[2:0];
                            n_t[9:5]   = i_write_data[7:3];
                            n_toggle   = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_t[14:8] = {1'b0, i_write_data[5:0]};
                            n_toggle  = 1'b1;
                        end else begin
                            n_t[7:0] = i_write_data;
                            n_v      = {r_t[14:8], i_write_data};
                            n_toggle = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        vid_en = 1'b1;
                        vid_we = 1'b1;
                        n_v    = r_v + step;
                    end
                endcase
            end
            CMD_LOAD_STATUS: begin
                n_status[7:5] = i_status_flags;
            end
            default: begin
            end
        endcase
    end

    pcrp_spram #(
        .DEPTH (OBJECT_TABLE_DEPTH),
        .WIDTH (8)
    ) u_oam (
        .i_clk   (i_clk),
        .i_en    (accept && oam_en),
        .i_we    (oam_we),
        .i_addr  (r_obj_addr[OAM_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (oam_q)
    );

    pcrp_spram #(
        .DEPTH (2 ** VIDEO_ADDR_BITS),
        .WIDTH (8)
    ) u_vram (
        .i_clk   (i_clk),
        .i_en    (accept && vid_en),
        .i_we    (vid_we),
        .i_addr  (r_v[VIDEO_ADDR_BITS-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (vid_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_mask     <= '0;
            r_status   <= '0;
            r_obj_addr <= '0;
            r_t        <= '0;
            r_v        <= '0;
            r_fine_x   <= '0;
            r_toggle   <= 1'b0;
        end else if (accept) begin
            r_ctrl     <= n_ctrl;
            r_mask     <= n_mask;
            r_status   <= n_status;
            r_obj_addr <= n_obj_addr;
            r_t        <= n_t;
            r_v        <= n_v;
            r_fine_x   <= n_fine_x;
            r_toggle   <= n_toggle;
        end
    end

    always_comb begin
        if (r_s1.sel_oam) begin
            s1_data = oam_q;
        end else if (r_s1.sel_vid) begin
            s1_data = r_s1.palette ? vid_q : r_read_buf;
        end else begin
            s1_data = r_s1.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_read_buf  <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv && r_s1.sel_vid) begin
                r_read_buf <= vid_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out_data <= s1_data;
            r_out_err  <= r_s1.err;
        end
    end

    // fine x is held for the rendering side, which is not part of this block
    logic unused_ok;
    assign unused_ok = ^{r_fine_x, r_mask};

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out_data;
    assign o_access_error = r_out_err && !unused_ok || r_out_err;

endmodule

`default_nettype wire
